### sv/eplf_pkg.sv
// Shared constants for the EPLF listing line parser: field widths,
// byte codes of the fact letters and the entry kind codes.
// No dependencies.
package eplf_pkg;

    localparam int POS_W              = 12;
    localparam int VALUE_W            = 64;
    localparam int ACC_W              = 63;
    localparam int LINE_BYTES_DEFAULT = 4096;

    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_R     = 8'h72;
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_S     = 8'h73;
    localparam logic [7:0] CHAR_M     = 8'h6D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_FILE = 2'd1;
    localparam logic [1:0] KIND_DIR  = 2'd2;

    // Largest signed 64-bit value, as an unsigned 63-bit accumulator bound
    localparam logic [ACC_W-1:0] VALUE_MAX = '1;

endpackage

### sv/eplf_listing_line_parser_core.sv
// EPLF listing line parser, top level: input register, per-byte fact parser
// and result register. Depends on eplf_pkg.
//
// Order: a line's last byte is taken into the input register, and its result is then registered in the result register.
// Throughput: one byte per cycle; the input register drains into the parser
// every cycle, and a last byte waits only while the result register is full.
// Reset: rst_n clears all control state; the parser starts on a fresh line.
module eplf_listing_line_parser_core #(
    parameter int LINE_BYTES = eplf_pkg::LINE_BYTES_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [7:0]                         line_byte,
    input  logic                               end_of_line,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               parsed_ok,
    output logic [1:0]                         entry_kind,
    output logic                               size_present,
    output logic signed [eplf_pkg::VALUE_W-1:0] size_value,
    output logic                               mtime_present,
    output logic signed [eplf_pkg::VALUE_W-1:0] mtime_value,
    output logic [eplf_pkg::POS_W-1:0]         name_offset,
    output logic [eplf_pkg::POS_W-1:0]         name_length,
    output logic                               line_too_long
);

    localparam int POS_W   = eplf_pkg::POS_W;
    localparam int ACC_W   = eplf_pkg::ACC_W;
    localparam int VALUE_W = eplf_pkg::VALUE_W;
    localparam int POS_TOP_INT = (LINE_BYTES > (2 ** POS_W)) ? (2 ** POS_W) - 1
                                                             : LINE_BYTES - 1;
    localparam logic [POS_W-1:0] POS_TOP = POS_W'(POS_TOP_INT);

    typedef enum logic [2:0] {
        PH_SKIP,
        PH_FACT,
        PH_SIZE_START,
        PH_MTIME_START,
        PH_SIZE_DIGITS,
        PH_MTIME_DIGITS,
        PH_IGNORE,
        PH_NAME
    } phase_t;

    // Input register
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;

    // Parser state
    phase_t           phase_reg, phase_next;
    logic [POS_W-1:0] idx_reg, idx_next;
    logic             top_reg, top_next;
    logic             sat_reg, sat_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             ovf_reg, ovf_next;
    logic [VALUE_W-1:0] size_reg, size_next;
    logic             size_seen_reg, size_seen_next;
    logic [VALUE_W-1:0] mtime_reg, mtime_next;
    logic             mtime_seen_reg, mtime_seen_next;
    logic [1:0]       kind_reg, kind_next;
    logic             found_reg, found_next;
    logic [POS_W-1:0] start_reg, start_next;

    // Result register
    logic             out_valid_reg;
    logic             ok_out_reg;
    logic [1:0]       kind_out_reg;
    logic             size_p_out_reg;
    logic [VALUE_W-1:0] size_out_reg;
    logic             mtime_p_out_reg;
    logic [VALUE_W-1:0] mtime_out_reg;
    logic [POS_W-1:0] offset_out_reg;
    logic [POS_W-1:0] length_out_reg;
    logic             long_out_reg;

    logic             advance;
    logic             emit;
    logic             is_digit;
    logic [3:0]       digit;
    logic             value_start;
    logic [ACC_W-1:0] acc_base;
    logic             ovf_base;
    logic [ACC_W+3:0] product;
    logic [VALUE_W-1:0] number;
    logic [7:0]       b;

    assign advance    = in_valid_reg && (!in_last_reg || !out_valid_reg || result_ready);
    assign emit       = advance && in_last_reg;
    assign item_ready = !in_valid_reg || advance;

    assign b        = in_byte_reg;
    assign is_digit = (b >= eplf_pkg::CHAR_ZERO) && (b <= eplf_pkg::CHAR_NINE);
    assign digit    = 4'(b - eplf_pkg::CHAR_ZERO);

    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        top_next        = top_reg;
        sat_next        = sat_reg | top_reg;
        size_next       = size_reg;
        size_seen_next  = size_seen_reg;
        mtime_next      = mtime_reg;
        mtime_seen_next = mtime_seen_reg;
        kind_next       = kind_reg;
        found_next      = found_reg;
        start_next      = start_reg;

        if (idx_reg < POS_TOP)
            idx_next = idx_reg + POS_W'(1);
        else
            top_next = 1'b1;

        // Accumulator restarts on the first value byte of a number fact
        value_start = (phase_reg == PH_SIZE_START) || (phase_reg == PH_MTIME_START);
        acc_base    = value_start ? '0 : acc_reg;
        ovf_base    = value_start ? 1'b0 : ovf_reg;
        product     = {4'b0, acc_base} * (ACC_W + 4)'(10) + (ACC_W + 4)'(digit);
        acc_next    = acc_reg;
        ovf_next    = ovf_reg;
        if ((value_start || phase_reg == PH_SIZE_DIGITS || phase_reg == PH_MTIME_DIGITS)
            && b != eplf_pkg::CHAR_COMMA)
        begin
            acc_next = acc_base;
            ovf_next = ovf_base;
            if (is_digit && !ovf_base)
            begin
                if (product > {4'b0, eplf_pkg::VALUE_MAX})
                    ovf_next = 1'b1;
                else
                    acc_next = product[ACC_W-1:0];
            end
        end
        number = ovf_next ? '1 : {1'b0, acc_next};

        case (phase_reg)
            PH_SKIP:
                phase_next = PH_FACT;
            PH_FACT:
            begin
                if (b == eplf_pkg::CHAR_TAB)
                    phase_next = PH_NAME;
                else if (b == eplf_pkg::CHAR_R)
                begin
                    kind_next  = eplf_pkg::KIND_FILE;
                    phase_next = PH_IGNORE;
                end
                else if (b == eplf_pkg::CHAR_SLASH)
                begin
                    kind_next  = eplf_pkg::KIND_DIR;
                    phase_next = PH_IGNORE;
                end
                else if (b == eplf_pkg::CHAR_S)
                    phase_next = PH_SIZE_START;
                else if (b == eplf_pkg::CHAR_M)
                    phase_next = PH_MTIME_START;
                else if (b != eplf_pkg::CHAR_COMMA)
                    phase_next = PH_IGNORE;
            end
            PH_SIZE_START, PH_MTIME_START, PH_SIZE_DIGITS, PH_MTIME_DIGITS:
            begin
                if (b == eplf_pkg::CHAR_COMMA)
                    phase_next = PH_FACT;
                else if (is_digit)
                    phase_next = (phase_reg == PH_SIZE_START || phase_reg == PH_SIZE_DIGITS)
                                 ? PH_SIZE_DIGITS : PH_MTIME_DIGITS;
                else
                    phase_next = PH_IGNORE;

                if (phase_reg == PH_SIZE_START || phase_reg == PH_SIZE_DIGITS)
                begin
                    if (b != eplf_pkg::CHAR_COMMA || phase_reg == PH_SIZE_DIGITS)
                        size_next = number;
                    if (b != eplf_pkg::CHAR_COMMA)
                        size_seen_next = 1'b1;
                end
                else
                begin
                    if (b != eplf_pkg::CHAR_COMMA || phase_reg == PH_MTIME_DIGITS)
                        mtime_next = number;
                    if (b != eplf_pkg::CHAR_COMMA)
                        mtime_seen_next = 1'b1;
                end
            end
            PH_IGNORE:
            begin
                if (b == eplf_pkg::CHAR_COMMA)
                    phase_next = PH_FACT;
            end
            PH_NAME:
            begin
                if (!found_reg)
                begin
                    found_next = 1'b1;
                    start_next = idx_reg;
                end
            end
            default:
                phase_next = PH_SKIP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_SKIP;
            idx_reg        <= '0;
            top_reg        <= 1'b0;
            sat_reg        <= 1'b0;
            acc_reg        <= '0;
            ovf_reg        <= 1'b0;
            size_reg       <= '0;
            size_seen_reg  <= 1'b0;
            mtime_reg      <= '0;
            mtime_seen_reg <= 1'b0;
            kind_reg       <= eplf_pkg::KIND_NONE;
            found_reg      <= 1'b0;
            start_reg      <= '0;
        end
        else
        begin
            if (item_ready)
                in_valid_reg <= item_valid;

            if (emit)
                out_valid_reg <= 1'b1;
            else if (result_ready)
                out_valid_reg <= 1'b0;

            if (emit)
            begin
                // Line done: return to the start-of-line state
                phase_reg      <= PH_SKIP;
                idx_reg        <= '0;
                top_reg        <= 1'b0;
                sat_reg        <= 1'b0;
                acc_reg        <= '0;
                ovf_reg        <= 1'b0;
                size_reg       <= '0;
                size_seen_reg  <= 1'b0;
                mtime_reg      <= '0;
                mtime_seen_reg <= 1'b0;
                kind_reg       <= eplf_pkg::KIND_NONE;
                found_reg      <= 1'b0;
                start_reg      <= '0;
            end
            else if (advance)
            begin
                phase_reg      <= phase_next;
                idx_reg        <= idx_next;
                top_reg        <= top_next;
                sat_reg        <= sat_next;
                acc_reg        <= acc_next;
                ovf_reg        <= ovf_next;
                size_reg       <= size_next;
                size_seen_reg  <= size_seen_next;
                mtime_reg      <= mtime_next;
                mtime_seen_reg <= mtime_seen_next;
                kind_reg       <= kind_next;
                found_reg      <= found_next;
                start_reg      <= start_next;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (item_ready && item_valid)
        begin
            in_byte_reg <= line_byte;
            in_last_reg <= end_of_line;
        end
        if (emit)
        begin
            ok_out_reg      <= found_next;
            kind_out_reg    <= kind_next;
            size_p_out_reg  <= size_seen_next;
            size_out_reg    <= size_seen_next ? size_next : '0;
            mtime_p_out_reg <= mtime_seen_next;
            mtime_out_reg   <= mtime_seen_next ? mtime_next : '0;
            offset_out_reg  <= found_next ? start_next : '0;
            length_out_reg  <= found_next ? (idx_reg + POS_W'(1) - start_next) : '0;
            long_out_reg    <= sat_next;
        end
    end

    assign result_valid  = out_valid_reg;
    assign parsed_ok     = ok_out_reg;
    assign entry_kind    = kind_out_reg;
    assign size_present  = size_p_out_reg;
    assign size_value    = size_out_reg;
    assign mtime_present = mtime_p_out_reg;
    assign mtime_value   = mtime_out_reg;
    assign name_offset   = offset_out_reg;
    assign name_length   = length_out_reg;
    assign line_too_long = long_out_reg;

endmodule
